// File: src/ski_pkg.sv
// Shared types and constants for the scalar keyframe interpolator.
// No dependencies; imported by the top level and its checker.
package ski_pkg;

    // Table geometry
    localparam int MAX_KEYS = 16;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = 5;

    // Operation codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Input word
    typedef struct packed {
        logic               op;
        logic        [31:0] key_time;
        logic signed [31:0] key_value;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic        [1:0]  status;
        logic [CNT_W-1:0]   key_count;
    } t_out_word;

endpackage

// File: src/scalar_keyframe_interpolator.sv
// Scalar keyframe interpolator: sorted keyframe table with linear sampling.
// Depends on ski_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   operation: insert a keyframe (op 0) or sample the track at a time (op 1).
//   Output channel (o_out_valid / i_out_ready / o_out_word) returns exactly
//   one word per input word, in order.
//   Inserts walk the table downward from the top, moving each later key up
//   by one slot, with a read state and a check state per key.
//   Samples check the first and last keys, then walk upward to the enclosing
//   interval (a read state and a check state per key, set by the registered
//   table read), then a 32x32 multiply and a restoring divider. End clamps
//   finish at the first or last key check, a dropped insert or an
//   empty-table sample straight from idle.
//   One operation is in flight at a time; o_in_ready is high only when idle.
//   The result sits in an output register; if the receiver stalls, the
//   block holds the word and waits to load the next one until it is taken.
//   Reset empties the table (key count zero) and clears the output valid
//   and r_fin; table contents are not cleared and no clearing pass is run.
module scalar_keyframe_interpolator
    import ski_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_INS_RD    = 12'b0000_0000_0010,
        S_INS_CHK   = 12'b0000_0000_0100,
        S_INS_PUT   = 12'b0000_0000_1000,
        S_FIRST_RD  = 12'b0000_0001_0000,
        S_FIRST_CHK = 12'b0000_0010_0000,
        S_LAST_RD   = 12'b0000_0100_0000,
        S_LAST_CHK  = 12'b0000_1000_0000,
        S_SCAN_RD   = 12'b0001_0000_0000,
        S_SCAN_CHK  = 12'b0010_0000_0000,
        S_MUL       = 12'b0100_0000_0000,
        S_DIV       = 12'b1000_0000_0000
    } t_state;

    // S_FIN is folded into a flag so the enum stays one-hot over work states
    t_state           r_state, n_state;
    logic             r_fin, n_fin;
    logic             r_op, n_op;
    logic [31:0]      r_t, n_t;
    logic [31:0]      r_v, n_v;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_lo_t, n_lo_t;
    logic [31:0]      r_lo_v, n_lo_v;
    logic             r_neg, n_neg;
    logic [31:0]      r_mag, n_mag;
    logic [31:0]      r_off, n_off;
    logic [31:0]      r_span, n_span;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_quo, n_quo;
    logic [4:0]       r_step, n_step;
    logic [31:0]      r_res, n_res;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    // Keyframe table, one write and one registered read per cycle
    logic [31:0]      r_mem_t [MAX_KEYS];
    logic [31:0]      r_mem_v [MAX_KEYS];
    logic [31:0]      r_rd_t, r_rd_v;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0]      mem_wt, mem_wv;

    // Shared datapath pieces
    logic [32:0]      dv;
    logic [63:0]      prod;
    logic [33:0]      trial;
    logic [IDX_W-1:0] idx_up;
    logic             in_acc;
    logic             out_load;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_t[mem_wa] <= mem_wt;
            r_mem_v[mem_wa] <= mem_wv;
        end
        r_rd_t <= r_mem_t[r_idx];
        r_rd_v <= r_mem_v[r_idx];
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_fin;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = r_fin && (!r_out_valid || i_out_ready);
    assign idx_up     = r_idx + IDX_W'(1);

    // Value delta, product and one restoring divide step
    assign dv    = {r_rd_v[31], r_rd_v} - {r_lo_v[31], r_lo_v};
    assign prod  = r_mag * r_off;
    assign trial = {1'b0, r_rem, r_quo[31]} - {2'b00, r_span};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_fin    = r_fin;
        n_op     = r_op;
        n_t      = r_t;
        n_v      = r_v;
        n_idx    = r_idx;
        n_count  = r_count;
        n_lo_t   = r_lo_t;
        n_lo_v   = r_lo_v;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_off    = r_off;
        n_span   = r_span;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_step   = r_step;
        n_res    = r_res;
        n_status = r_status;
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wt   = r_t;
        mem_wv   = r_v;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_in_word.op;
                    n_t      = i_in_word.key_time;
                    n_v      = i_in_word.key_value;
                    n_res    = '0;
                    n_status = ST_OK;
                    if (i_in_word.op == OP_INSERT) begin
                        if (r_count == CNT_W'(MAX_KEYS)) begin
                            n_status = ST_FULL;
                            n_fin    = 1'b1;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = S_INS_PUT;
                        end else begin
                            n_idx   = IDX_W'(r_count - CNT_W'(1));
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_fin    = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = S_FIRST_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                n_state = S_INS_CHK;
            end
            // Move later keys up one slot until a key at or below the new time, then store the new key above it
            S_INS_CHK: begin
                mem_we = 1'b1;
                mem_wa = idx_up;
                if (r_rd_t > r_t) begin
                    mem_wt = r_rd_t;
                    mem_wv = r_rd_v;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                end
            end
            S_INS_PUT: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
                n_fin   = 1'b1;
            end
            S_FIRST_RD: begin
                n_state = S_FIRST_CHK;
            end
            // Clamp at or before the first key
            S_FIRST_CHK: begin
                n_lo_t = r_rd_t;
                n_lo_v = r_rd_v;
                if (r_t <= r_rd_t) begin
                    n_res   = r_rd_v;
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                end else begin
                    n_idx   = IDX_W'(r_count - CNT_W'(1));
                    n_state = S_LAST_RD;
                end
            end
            S_LAST_RD: begin
                n_state = S_LAST_CHK;
            end
            // Clamp at or after the last key
            S_LAST_CHK: begin
                if (r_t >= r_rd_t) begin
                    n_res   = r_rd_v;
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                end else begin
                    n_idx   = IDX_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            // Walk up to the first key at or above the sample time
            S_SCAN_CHK: begin
                if (r_t <= r_rd_t) begin
                    n_span  = r_rd_t - r_lo_t;
                    n_off   = r_t - r_lo_t;
                    n_neg   = dv[32];
                    n_mag   = dv[32] ? 32'(-dv) : dv[31:0];
                    n_state = S_MUL;
                end else begin
                    n_lo_t  = r_rd_t;
                    n_lo_v  = r_rd_v;
                    n_idx   = idx_up;
                    n_state = S_SCAN_RD;
                end
            end
            // High half is below the span, so 32 steps give the quotient
            S_MUL: begin
                n_rem   = prod[63:32];
                n_quo   = prod[31:0];
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_quo = {r_quo[30:0], ~trial[33]};
                n_rem = trial[33] ? {r_rem[30:0], r_quo[31]} : trial[31:0];
                n_step = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_state = S_IDLE;
                    n_fin   = 1'b1;
                    n_res   = r_neg ? (r_lo_v - {r_quo[30:0], ~trial[33]})
                                    : (r_lo_v + {r_quo[30:0], ~trial[33]});
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the finished word to the output register and count a successful insert
        if (out_load) begin
            n_fin = 1'b0;
            if (r_op == OP_INSERT && r_status == ST_OK) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid          = 1'b1;
            n_out.sample_value   = r_res;
            n_out.status         = r_status;
            n_out.key_count      = n_count;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= n_fin;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_t      <= n_t;
        r_v      <= n_v;
        r_idx    <= n_idx;
        r_lo_t   <= n_lo_t;
        r_lo_v   <= n_lo_v;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_off    <= n_off;
        r_span   <= n_span;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_step   <= n_step;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// File: src/ski_checker.sv
// Port-level checker for the scalar keyframe interpolator, with its bind.
// Depends on ski_pkg and the top level scalar_keyframe_interpolator.
module ski_port_checks
    import ski_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // One operation at a time: busy right after accepting a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // Key count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.key_count <= CNT_W'(MAX_KEYS))
        else $error("key count out of range");

    // A dropped insert only happens on a full table and returns zero
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_FULL |->
            o_out_word.key_count == CNT_W'(MAX_KEYS) && o_out_word.sample_value == 0)
        else $error("bad table-full word");

    // An empty-table sample reports zero keys and zero value
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_EMPTY |->
            o_out_word.key_count == '0 && o_out_word.sample_value == 0)
        else $error("bad empty-table word");

endmodule

bind scalar_keyframe_interpolator ski_port_checks u_ski_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
